// ===== rtl/rpr_pkg.sv =====
// ----------------------------------------------------------------------------
// rpr_pkg: shared definitions for the reflection row padder
// Sizes of the row buffer, register widths, register indexes, the sequencer
// states and the request bundle to the source index unit.
// ----------------------------------------------------------------------------
package rpr_pkg;

  localparam int MAX_ROW   = 64;
  localparam int ADDR_W    = $clog2(MAX_ROW);
  localparam int ELEM_W    = 32;
  localparam int LEN_W     = 7;
  localparam int PAD_W     = 5;
  localparam int CNT_W     = 6;
  localparam int BURST_CAP = 63;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 7;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_LEFT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_RIGHT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DRAIN_RD,
    ST_DRAIN_OUT,
    ST_WRITE,
    ST_ROW_RD,
    ST_ROW_OUT
  } state_t;

  // Position in the padded row plus the row geometry it is resolved against.
  typedef struct packed {
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] len;
    logic [PAD_W-1:0] pad;
  } src_req_t;

endpackage

// ===== rtl/rpr_ram.sv =====
// ----------------------------------------------------------------------------
// rpr_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data. The read data
// holds its value until the next read enable.
// ----------------------------------------------------------------------------
module rpr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/rpr_src_unit.sv =====
// ----------------------------------------------------------------------------
// rpr_src_unit: source index of one padded position
// Maps a position of the padded row to the row buffer entry it mirrors:
// left pad, the row itself, or the right pad reflected about the last element.
// ----------------------------------------------------------------------------
module rpr_src_unit
  import rpr_pkg::*;
(
  input  src_req_t          req,
  output logic [ADDR_W-1:0] src
);

  logic [7:0] j;
  logic [7:0] k;
  logic [7:0] pl;
  logic [7:0] plk;
  logic [7:0] r;
  logic [7:0] s;

  always_comb begin
    j   = {1'b0, req.pos};
    k   = {1'b0, req.len};
    pl  = {3'b000, req.pad};
    plk = pl + k;
    r   = j - plk;
    if (j < pl) begin
      s = pl - j;
    end else if (j < plk) begin
      s = j - pl;
    end else if (r + 8'd2 <= k) begin
      s = k - 8'd2 - r;
    end else begin
      s = 8'd0;
    end
    src = s[ADDR_W-1:0];
  end

endmodule

// ===== rtl/reflection_pad_row.sv =====
// ----------------------------------------------------------------------------
// reflection_pad_row: mirror padding of a stream of rows
// Elements are stored in a row buffer and the padded row is read back out of
// it, one result per buffer read, with the edge element not repeated.
// ----------------------------------------------------------------------------
// Operation: an element that releases no result is accepted, then written
// to the row buffer. Every result is a row buffer read through the shared
// source index unit, then presented on the output register, held while the
// output side stalls. The buffer's single read port and this read/present
// loop set the rate; no new element is taken until its results are all out.
// Reset clears the sequencer, counters and configuration registers
// (row_len 64, pads 0); the row buffer is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module reflection_pad_row
  import rpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write port.
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // Input element channel.
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ELEM_W-1:0]    elem_value,
  // Result channel.
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ELEM_W-1:0]    out_value,
  output logic                 row_end,
  output logic                 burst_last
);

  // Configuration registers.
  logic [LEN_W-1:0] row_len;
  logic [PAD_W-1:0] pad_left;
  logic [PAD_W-1:0] pad_right;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_len   <= LEN_W'(MAX_ROW);
      pad_left  <= '0;
      pad_right <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_ROW_LEN:   row_len   <= cfg_data[LEN_W-1:0];
        REG_PAD_LEFT:  pad_left  <= cfg_data[PAD_W-1:0];
        REG_PAD_RIGHT: pad_right <= cfg_data[PAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective row geometry. A length of zero acts as one, and lengths above
  // the buffer depth are clamped to it. Pads saturate at one less than the
  // row length, so a reflection never reaches past the far edge.
  logic [LEN_W-1:0] k;
  logic [LEN_W-1:0] km1;
  logic [PAD_W-1:0] pl;
  logic [PAD_W-1:0] pr;
  logic [LEN_W-1:0] total;

  always_comb begin
    if (row_len == '0) begin
      k = LEN_W'(1);
    end else if (row_len > LEN_W'(MAX_ROW)) begin
      k = LEN_W'(MAX_ROW);
    end else begin
      k = row_len;
    end
    km1   = k - LEN_W'(1);
    pl    = ({2'b00, pad_left} > km1) ? km1[PAD_W-1:0] : pad_left;
    pr    = ({2'b00, pad_right} > km1) ? km1[PAD_W-1:0] : pad_right;
    total = k + {2'b00, pl} + {2'b00, pr};
  end

  // Row tracking state.
  logic [LEN_W-1:0]  col_count;
  logic [LEN_W-1:0]  emit_pos;
  logic              drain;

  // Per-transfer working registers.
  logic [ELEM_W-1:0] elem;
  logic [ADDR_W-1:0] wr_col;
  logic [LEN_W-1:0]  pos;
  logic [LEN_W-1:0]  row_pos;
  logic [CNT_W-1:0]  cnt_a;
  logic [CNT_W-1:0]  cnt_b;

  state_t state;
  state_t state_next;

  // Plan of one input transfer, worked out from the row state when the
  // element arrives. Segment A is what a finished row still owes, up to the
  // burst cap; then the element is stored and segment B covers the positions
  // it releases. Both segments together never exceed the per-transfer burst cap.
  logic [LEN_W-1:0] owed;
  logic [CNT_W-1:0] plan_a;
  logic             restart;
  logic [LEN_W-1:0] col1;
  logic [LEN_W-1:0] col1_inc;
  logic [LEN_W-1:0] ep1;
  logic [LEN_W-1:0] frontier;
  logic [LEN_W-1:0] span;
  logic [CNT_W-1:0] room;
  logic [CNT_W-1:0] plan_b;

  always_comb begin
    owed = total - emit_pos;
    if (drain && (emit_pos < total)) begin
      plan_a = (owed > LEN_W'(BURST_CAP)) ? CNT_W'(BURST_CAP) : owed[CNT_W-1:0];
    end else begin
      plan_a = '0;
    end

    // A finished row, or one made too long by a shorter row length, starts
    // over with this element.
    restart  = drain || (col_count >= k);
    col1     = restart ? '0 : col_count;
    ep1      = restart ? '0 : emit_pos;
    col1_inc = col1 + LEN_W'(1);

    // The last element releases the rest of the row including the right pad.
    // Before that, output runs up to the element just stored, once the left
    // pad's farthest source has arrived.
    if (col1_inc == k) begin
      frontier = total;
    end else if (col1 >= {2'b00, pl}) begin
      frontier = {2'b00, pl} + col1_inc;
    end else begin
      frontier = '0;
    end

    span = frontier - ep1;
    room = CNT_W'(BURST_CAP) - plan_a;
    if (ep1 < frontier) begin
      plan_b = (span > {1'b0, room}) ? room : span[CNT_W-1:0];
    end else begin
      plan_b = '0;
    end
  end

  logic in_xfer;
  logic out_xfer;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (plan_a != '0) ? ST_DRAIN_RD : ST_WRITE;
        end
      end
      ST_DRAIN_RD: state_next = ST_DRAIN_OUT;
      ST_DRAIN_OUT: begin
        if (!out_stall) begin
          state_next = (cnt_a == CNT_W'(1)) ? ST_WRITE : ST_DRAIN_RD;
        end
      end
      ST_WRITE: state_next = (cnt_b != '0) ? ST_ROW_RD : ST_IDLE;
      ST_ROW_RD: state_next = ST_ROW_OUT;
      ST_ROW_OUT: begin
        if (!out_stall) begin
          state_next = (cnt_b == CNT_W'(1)) ? ST_IDLE : ST_ROW_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer outputs.
  logic rd_en;
  logic wr_en;

  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    case (state)
      ST_IDLE:      in_stall  = 1'b0;
      ST_DRAIN_RD:  rd_en     = 1'b1;
      ST_DRAIN_OUT: out_valid = 1'b1;
      ST_WRITE:     wr_en     = 1'b1;
      ST_ROW_RD:    rd_en     = 1'b1;
      ST_ROW_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  // Row state advances when the element is taken; the step always runs to
  // completion before the next element is accepted.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      emit_pos  <= '0;
      drain     <= 1'b0;
      cnt_a     <= '0;
      cnt_b     <= '0;
    end else begin
      if (in_xfer) begin
        col_count <= col1_inc;
        emit_pos  <= ep1 + {1'b0, plan_b};
        drain     <= (col1_inc == k);
        cnt_a     <= plan_a;
        cnt_b     <= plan_b;
      end else if (out_xfer) begin
        if (state == ST_DRAIN_OUT) begin
          cnt_a <= cnt_a - CNT_W'(1);
        end else begin
          cnt_b <= cnt_b - CNT_W'(1);
        end
      end
    end
  end

  // Payload-side registers need no reset.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      elem    <= elem_value;
      wr_col  <= col1[ADDR_W-1:0];
      pos     <= emit_pos;
      row_pos <= ep1;
    end else if (state == ST_WRITE) begin
      pos <= row_pos;
    end else if (out_xfer) begin
      pos <= pos + LEN_W'(1);
    end
  end

  // Shared source index unit, used once per result.
  src_req_t          req;
  logic [ADDR_W-1:0] src;

  assign req = '{pos: pos, len: k, pad: pl};

  rpr_src_unit u_src (
    .req (req),
    .src (src)
  );

  rpr_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (MAX_ROW)
  ) u_row_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_col),
    .wr_data (elem),
    .rd_en   (rd_en),
    .rd_addr (src),
    .rd_data (out_value)
  );

  // Flags of the result on show; pos and the counters hold while stalled.
  assign row_end    = (pos + LEN_W'(1)) == total;
  assign burst_last = (state == ST_DRAIN_OUT) ? ((cnt_a == CNT_W'(1)) && (cnt_b == '0))
                                              : (cnt_b == CNT_W'(1));

endmodule
